[rtl/core/number_literal_recognizer_macros.svh]
// Assertion macros used by the checker module of the number literal recognizer.
`ifndef NUMBER_LITERAL_RECOGNIZER_MACROS_SVH
`define NUMBER_LITERAL_RECOGNIZER_MACROS_SVH

// Clocked assertion, off while reset is held.
`define NLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define NLR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/nlr_pkg.sv]
// Types and constants of the number literal recognizer.
package nlr_pkg;

  typedef enum logic [1:0] {
    PH_NEED  = 2'd0,
    PH_DIGIT = 2'd1,
    PH_DEAD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] pos;
    phase_t     ph_bin;
    phase_t     ph_oct;
    phase_t     ph_hex;
    phase_t     ph_dec;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    pos:    2'd0,
    ph_bin: PH_NEED,
    ph_oct: PH_NEED,
    ph_hex: PH_NEED,
    ph_dec: PH_NEED
  };

  localparam logic [1:0] POS_MAX = 2'd2;

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;
  localparam logic [1:0] BASE_DEC = 2'd3;

  localparam logic CFG_SEP_ENABLE = 1'b0;
  localparam logic CFG_SEP_CHAR   = 1'b1;

  localparam logic [7:0] SEP_CHAR_RESET = 8'd95;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_O = 8'h6f;
  localparam logic [7:0] CH_LOW_X = 8'h78;

endpackage

[rtl/core/nlr_step.sv]
// One character step of the four literal recognizers, plus the verdict for a last beat.
module nlr_step (
  input  nlr_pkg::scan_state_t st,
  input  logic [7:0]           ch,
  input  logic                 sep_enable,
  input  logic [7:0]           sep_char,
  output nlr_pkg::scan_state_t st_nxt,
  output logic                 is_literal,
  output logic [1:0]           base
);
  import nlr_pkg::*;

  logic dig_bin, dig_oct, dig_dec, dig_hex, sep_hit;

  function automatic phase_t body_step(phase_t ph, logic dig, logic sep);
    phase_t res;
    res = PH_DEAD;
    case (ph)
      PH_NEED:  res = dig ? PH_DIGIT : PH_DEAD;
      PH_DIGIT: res = dig ? PH_DIGIT : (sep ? PH_NEED : PH_DEAD);
      default:  res = PH_DEAD;
    endcase
    return res;
  endfunction

  function automatic phase_t prefix_step(phase_t ph, logic [1:0] pos, logic [7:0] c,
                                         logic [7:0] letter, logic dig, logic sep);
    phase_t res;
    res = PH_DEAD;
    case (pos)
      2'd0:    res = (ph == PH_NEED && c == CH_ZERO) ? PH_NEED : PH_DEAD;
      2'd1:    res = (ph == PH_NEED && c == letter) ? PH_NEED : PH_DEAD;
      default: res = body_step(ph, dig, sep);
    endcase
    return res;
  endfunction

  always_comb begin
    dig_bin = (ch inside {[8'h30:8'h31]});
    dig_oct = (ch inside {[8'h30:8'h37]});
    dig_dec = (ch inside {[8'h30:8'h39]});
    dig_hex = (ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    sep_hit = sep_enable && (ch == sep_char);
  end

  always_comb begin
    st_nxt.pos    = (st.pos == POS_MAX) ? POS_MAX : st.pos + 2'd1;
    st_nxt.ph_bin = prefix_step(st.ph_bin, st.pos, ch, CH_LOW_B, dig_bin, sep_hit);
    st_nxt.ph_oct = prefix_step(st.ph_oct, st.pos, ch, CH_LOW_O, dig_oct, sep_hit);
    st_nxt.ph_hex = prefix_step(st.ph_hex, st.pos, ch, CH_LOW_X, dig_hex, sep_hit);
    st_nxt.ph_dec = body_step(st.ph_dec, dig_dec, sep_hit);
  end

  // Priority: binary, octal, hex, decimal.
  always_comb begin
    is_literal = 1'b1;
    base       = BASE_BIN;
    if (st_nxt.ph_bin == PH_DIGIT) begin
      base = BASE_BIN;
    end else if (st_nxt.ph_oct == PH_DIGIT) begin
      base = BASE_OCT;
    end else if (st_nxt.ph_hex == PH_DIGIT) begin
      base = BASE_HEX;
    end else if (st_nxt.ph_dec == PH_DIGIT) begin
      base = BASE_DEC;
    end else begin
      is_literal = 1'b0;
      base       = BASE_BIN;
    end
  end

endmodule

[rtl/core/number_literal_recognizer.sv]
// Number literal recognizer: top level with input stage, token state and result register.
//
// Tokens stream in on the in_ channel, one character per beat, with in_tlast on
// the final character. Binary (0b), octal (0o), hex (0x) and prefix-free decimal
// recognizers track the token side by side; an optional single separator byte
// may stand between digits. Each last beat yields one result beat on out_:
// is_literal and the base code (binary, octal, hex, decimal by priority).
// Non-last beats yield nothing.
//
// A last beat passes the input register, then the result register, to out_.
// Throughput: one character per cycle unless a stall holds a last beat; the
// input and result registers let a new beat in while a finished result waits
// on out_tready. When the receiver stalls, the result holds and one more last
// beat may park in the input register; further input backs up through in_tready.
// Reset (rst_n low at a clock edge) empties both stages, starts a fresh token,
// disables separators and sets the separator byte to '_'.
// Configuration writes take effect at once and belong between tokens.
module number_literal_recognizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] is_literal, [2:1] base, [7:3] zero
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import nlr_pkg::*;

  logic        sep_enable_r;
  logic [7:0]  sep_char_r;

  logic        s1_valid_r;
  logic [7:0]  s1_ch_r;
  logic        s1_last_r;

  scan_state_t st_r;
  scan_state_t st_step;
  logic        step_literal;
  logic [1:0]  step_base;

  logic        out_valid_r;
  logic        lit_r;
  logic [1:0]  base_r;

  logic        out_free;
  logic        s1_adv;
  logic        in_fire;

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    s1_adv    = s1_valid_r && (!s1_last_r || out_free);
    in_tready = !s1_valid_r || s1_adv;
    in_fire   = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_enable_r <= 1'b0;
      sep_char_r   <= SEP_CHAR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SEP_ENABLE: sep_enable_r <= cfg_wdata[0];
        CFG_SEP_CHAR:   sep_char_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  nlr_step u_step (
    .st         (st_r),
    .ch         (s1_ch_r),
    .sep_enable (sep_enable_r),
    .sep_char   (sep_char_r),
    .st_nxt     (st_step),
    .is_literal (step_literal),
    .base       (step_base)
  );

  // Token state moves with the beat leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_RESET;
    end else if (s1_adv) begin
      st_r <= s1_last_r ? SCAN_RESET : st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      lit_r  <= step_literal;
      base_r <= step_base;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, base_r, lit_r};

endmodule

[rtl/core/nlr_checker.sv]
// Port-level checks for the number literal recognizer, bound to the top level.
`include "number_literal_recognizer_macros.svh"

module nlr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `NLR_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result beat right after reset")

  `NLR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")

  `NLR_ASSERT(a_base_zero, out_tvalid && !out_tdata[0] |-> out_tdata[2:1] == 2'd0 && out_tdata[7:3] == 5'd0, "rejected token carries a base")

  // A result that appears from an empty output must come from a last beat taken in through the input register.
  `NLR_ASSERT(a_rise_from_last, $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2), "result without a matching last beat")

endmodule

bind number_literal_recognizer nlr_checker u_nlr_checker (.*);
